@@ src/dema_pkg.sv @@
// dema_pkg: shared constants, types and tables of the 3x3 aspect core
// no dependencies; imported by every module of the block except dema_skid
`default_nettype none

package dema_pkg;

  // default parameter values
  localparam int ELEV_BITS_DEF       = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 6;

  // angles are carried in 2^-20 degree; 360 degrees fits in ANG_W bits
  localparam int ANG_BITS = 20;
  localparam int ANG_W    = ANG_BITS + 9;

  // vectoring rotator: step count, datapath width, normalization target
  localparam int CORDIC_STEPS = 27;
  localparam int CW           = 44;
  localparam int NORM_MSB     = 39;
  localparam int SH_W         = 6;

  localparam logic [ANG_W-1:0] ANG_90  = ANG_W'(90 * (2 ** ANG_BITS));
  localparam logic [ANG_W-1:0] ANG_270 = ANG_W'(270 * (2 ** ANG_BITS));

  // window cell positions, row 0 is north
  localparam int CELL_NW = 0;
  localparam int CELL_N  = 1;
  localparam int CELL_NE = 2;
  localparam int CELL_W  = 3;
  localparam int CELL_C  = 4;
  localparam int CELL_E  = 5;
  localparam int CELL_SW = 6;
  localparam int CELL_S  = 7;
  localparam int CELL_SE = 8;
  localparam int N_CELLS = 9;

  // arctangent of 2^-i in 2^-20 degree, rounded to nearest
  localparam logic [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    ANG_W'(47185920), ANG_W'(27855475), ANG_W'(14718068), ANG_W'(7471121),
    ANG_W'(3750058),  ANG_W'(1876857),  ANG_W'(938658),   ANG_W'(469357),
    ANG_W'(234682),   ANG_W'(117342),   ANG_W'(58671),    ANG_W'(29335),
    ANG_W'(14668),    ANG_W'(7334),     ANG_W'(3667),     ANG_W'(1833),
    ANG_W'(917),      ANG_W'(458),      ANG_W'(229),      ANG_W'(115),
    ANG_W'(57),       ANG_W'(29),       ANG_W'(14),       ANG_W'(7),
    ANG_W'(4),        ANG_W'(2),        ANG_W'(1)
  };

  typedef enum logic [1:0] {
    ST_VALID  = 2'd0,
    ST_BORDER = 2'd1,
    ST_NODATA = 2'd2,
    ST_FLAT   = 2'd3
  } status_e;

  // control bits that travel with each window down the pipeline
  typedef struct packed {
    logic vld;
    logic border;
    logic nodata;
    logic flat;
    logic dx_pos;   // dx > 0, i.e. the rotated x axis points west
    logic dy_neg;   // dy < 0
    logic a_zero;   // |dx| == 0
    logic b_zero;   // |dy| == 0
  } dema_side_t;

endpackage

`default_nettype wire

@@ src/dema_win_if.sv @@
// dema_win_if: input channel carrying one 3x3 window and the border flag
// uses dema_pkg for the default elevation width
`default_nettype none

interface dema_win_if #(
  parameter int ELEV_BITS = dema_pkg::ELEV_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [ELEV_BITS-1:0] elev_nw;
  logic signed [ELEV_BITS-1:0] elev_n;
  logic signed [ELEV_BITS-1:0] elev_ne;
  logic signed [ELEV_BITS-1:0] elev_w;
  logic signed [ELEV_BITS-1:0] elev_c;
  logic signed [ELEV_BITS-1:0] elev_e;
  logic signed [ELEV_BITS-1:0] elev_sw;
  logic signed [ELEV_BITS-1:0] elev_s;
  logic signed [ELEV_BITS-1:0] elev_se;
  logic                        at_border;

  modport source (
    output valid, elev_nw, elev_n, elev_ne, elev_w, elev_c, elev_e,
           elev_sw, elev_s, elev_se, at_border,
    input  ready
  );

  modport sink (
    input  valid, elev_nw, elev_n, elev_ne, elev_w, elev_c, elev_e,
           elev_sw, elev_s, elev_se, at_border,
    output ready
  );
endinterface

`default_nettype wire

@@ src/dema_res_if.sv @@
// dema_res_if: output channel carrying azimuth and status of one window
// uses dema_pkg for the default angle resolution
`default_nettype none

interface dema_res_if #(
  parameter int AZ_BITS = $clog2(360 * (2 ** dema_pkg::ANGLE_FRAC_BITS_DEF))
) ();
  logic               valid;
  logic               ready;
  logic [AZ_BITS-1:0] azimuth;
  logic [1:0]         status;

  modport source (
    output valid, azimuth, status,
    input  ready
  );

  modport sink (
    input  valid, azimuth, status,
    output ready
  );
endinterface

`default_nettype wire

@@ src/dema_front.sv @@
// dema_front: Horn gradients, null check, magnitudes and normalization
// six register stages; uses dema_pkg for widths, cell positions and side struct
`default_nettype none

module dema_front #(
  parameter int ELEV_BITS = dema_pkg::ELEV_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic [dema_pkg::N_CELLS-1:0][ELEV_BITS-1:0] cells_i,
  input  logic                                       at_border_i,
  input  logic [ELEV_BITS-1:0]                       nodata_i,
  output logic signed [dema_pkg::CW-1:0]             x_o,
  output logic signed [dema_pkg::CW-1:0]             y_o,
  output dema_pkg::dema_side_t                       side_o
);
  import dema_pkg::*;

  localparam int SW = ELEV_BITS + 2;  // weighted row or column sum
  localparam int DW = ELEV_BITS + 3;  // gradient
  localparam int MW = ELEV_BITS + 2;  // gradient magnitude

  // p + 2q + r on sign-extended cells
  function automatic logic [SW-1:0] wsum(input logic [ELEV_BITS-1:0] p,
                                         input logic [ELEV_BITS-1:0] q,
                                         input logic [ELEV_BITS-1:0] r);
    return {{2{p[ELEV_BITS-1]}}, p} + {q[ELEV_BITS-1], q, 1'b0}
         + {{2{r[ELEV_BITS-1]}}, r};
  endfunction

  dema_side_t side0_q, side1_q, side2_q, side3_q, side4_q, side5_q;
  dema_side_t side0_d, side2_d;

  logic [SW-1:0] east_q, west_q, south_q, north_q;
  logic [DW-1:0] dx_q, dy_q;
  logic [MW-1:0] a2_q, b2_q, a3_q, b3_q, m3_q, a4_q, b4_q;
  logic [SW-1:0] east_d, west_d, south_d, north_d;
  logic [DW-1:0] dx_d, dy_d;
  logic [MW-1:0] a_d, b_d, m_d;
  logic [SH_W-1:0] sh_d, sh_q;
  logic signed [CW-1:0] x_d, y_d, x_q, y_q;
  logic          null_d;

  // stage 0: weighted sums and nodata search over the whole window
  always_comb begin
    null_d = 1'b0;
    for (int k = 0; k < N_CELLS; k++) begin
      if (cells_i[k] == nodata_i) null_d = 1'b1;
    end
    east_d  = wsum(cells_i[CELL_NE], cells_i[CELL_E], cells_i[CELL_SE]);
    west_d  = wsum(cells_i[CELL_NW], cells_i[CELL_W], cells_i[CELL_SW]);
    south_d = wsum(cells_i[CELL_SW], cells_i[CELL_S], cells_i[CELL_SE]);
    north_d = wsum(cells_i[CELL_NW], cells_i[CELL_N], cells_i[CELL_NE]);
    side0_d = '0;
    side0_d.vld    = valid_i;
    side0_d.border = at_border_i;
    side0_d.nodata = null_d;
  end

  // stage 1: gradients east minus west, south minus north
  assign dx_d = {east_q[SW-1], east_q} - {west_q[SW-1], west_q};
  assign dy_d = {south_q[SW-1], south_q} - {north_q[SW-1], north_q};

  // stage 2: magnitudes and quadrant flags
  always_comb begin
    a_d = dx_q[DW-1] ? MW'(-dx_q) : MW'(dx_q);
    b_d = dy_q[DW-1] ? MW'(-dy_q) : MW'(dy_q);
    side2_d        = side1_q;
    side2_d.a_zero = (dx_q == '0);
    side2_d.b_zero = (dy_q == '0);
    side2_d.flat   = (dx_q == '0) && (dy_q == '0);
    side2_d.dx_pos = ~dx_q[DW-1] && (dx_q != '0);
    side2_d.dy_neg = dy_q[DW-1];
  end

  // stage 3: larger magnitude
  assign m_d = (a2_q > b2_q) ? a2_q : b2_q;

  // stage 4: shift that brings the larger magnitude to the normalization msb
  always_comb begin
    sh_d = SH_W'(NORM_MSB);
    for (int i = 0; i < MW; i++) begin
      if (m3_q[i]) sh_d = SH_W'(NORM_MSB - i);
    end
  end

  // stage 5: normalized rotator inputs
  assign x_d = CW'(a4_q) << sh_q;
  assign y_d = CW'(b4_q) << sh_q;

  // control chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side0_q <= '0;
      side1_q <= '0;
      side2_q <= '0;
      side3_q <= '0;
      side4_q <= '0;
      side5_q <= '0;
    end else if (en_i) begin
      side0_q <= side0_d;
      side1_q <= side0_q;
      side2_q <= side2_d;
      side3_q <= side2_q;
      side4_q <= side3_q;
      side5_q <= side4_q;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      east_q  <= east_d;
      west_q  <= west_d;
      south_q <= south_d;
      north_q <= north_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      a2_q    <= a_d;
      b2_q    <= b_d;
      a3_q    <= a2_q;
      b3_q    <= b2_q;
      m3_q    <= m_d;
      a4_q    <= a3_q;
      b4_q    <= b3_q;
      sh_q    <= sh_d;
      x_q     <= x_d;
      y_q     <= y_d;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign side_o = side5_q;

endmodule

`default_nettype wire

@@ src/dema_cordic.sv @@
// dema_cordic: vectoring rotator, one micro-rotation per register stage
// uses dema_pkg for the arctangent table, widths and side struct
`default_nettype none

module dema_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic signed [dema_pkg::CW-1:0]      x_i,
  input  logic signed [dema_pkg::CW-1:0]      y_i,
  input  dema_pkg::dema_side_t                side_i,
  output logic signed [dema_pkg::ANG_W-1:0]   z_o,
  output dema_pkg::dema_side_t                side_o
);
  import dema_pkg::*;

  logic signed [CW-1:0]    x_q    [CORDIC_STEPS-1];
  logic signed [CW-1:0]    y_q    [CORDIC_STEPS-1];
  logic signed [ANG_W-1:0] z_q    [CORDIC_STEPS];
  dema_side_t              side_q [CORDIC_STEPS];

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
    logic signed [CW-1:0]    yin;
    logic signed [ANG_W-1:0] zin, z_d;
    dema_side_t              sin;
    logic                    rot_neg;

    if (s == 0) begin : g_first
      assign yin = y_i;
      assign zin = '0;
      assign sin = side_i;
    end else begin : g_next
      assign yin = y_q[s-1];
      assign zin = z_q[s-1];
      assign sin = side_q[s-1];
    end

    // rotate toward the x axis, accumulate the angle
    assign rot_neg = ~yin[CW-1];
    assign z_d     = rot_neg ? zin + ATAN_TAB[s] : zin - ATAN_TAB[s];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s] <= '0;
      end else if (en_i) begin
        side_q[s] <= sin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[s] <= z_d;
      end
    end

    // the last step only needs the angle
    if (s < CORDIC_STEPS - 1) begin : g_xy
      logic signed [CW-1:0] xin, xs, ys, x_d, y_d;

      if (s == 0) begin : g_xfirst
        assign xin = x_i;
      end else begin : g_xnext
        assign xin = x_q[s-1];
      end

      assign xs  = xin >>> s;
      assign ys  = yin >>> s;
      assign x_d = rot_neg ? xin + ys : xin - ys;
      assign y_d = rot_neg ? yin - xs : yin + xs;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[s] <= x_d;
          y_q[s] <= y_d;
        end
      end
    end
  end

  assign z_o    = z_q[CORDIC_STEPS-1];
  assign side_o = side_q[CORDIC_STEPS-1];

endmodule

`default_nettype wire

@@ src/dema_post.sv @@
// dema_post: angle clamp, quadrant mapping to compass azimuth, rounding, status
// two register stages then output logic; uses dema_pkg
`default_nettype none

module dema_post #(
  parameter int ANGLE_FRAC_BITS = dema_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int AZ_BITS         = $clog2(360 * (2 ** ANGLE_FRAC_BITS))
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic signed [dema_pkg::ANG_W-1:0]  z_i,
  input  dema_pkg::dema_side_t               side_i,
  output logic                               valid_o,
  output logic [AZ_BITS-1:0]                 azimuth_o,
  output dema_pkg::status_e                  status_o
);
  import dema_pkg::*;

  localparam int                 ANG_SHIFT = ANG_BITS - ANGLE_FRAC_BITS;
  localparam logic [ANG_W-1:0]   RND       = ANG_W'(1) << (ANG_SHIFT - 1);
  localparam logic [AZ_BITS-1:0] AZ_FULL   = AZ_BITS'(360 * (2 ** ANGLE_FRAC_BITS));

  dema_side_t       side_p0_q, side_p1_q;
  logic [ANG_W-1:0] phi_d, phi_q, az_d, az_q, az_rnd;
  logic [AZ_BITS-1:0] az_res;

  // first-quadrant angle: exact axes when one gradient is zero, else clamped
  always_comb begin
    priority if (side_i.a_zero) begin
      phi_d = ANG_90;
    end else if (side_i.b_zero) begin
      phi_d = '0;
    end else if (z_i[ANG_W-1]) begin
      phi_d = '0;
    end else if ($unsigned(z_i) > ANG_90) begin
      phi_d = ANG_90;
    end else begin
      phi_d = $unsigned(z_i);
    end
  end

  // compass azimuth, 90 degrees minus the math angle, wrapped to 0..360
  always_comb begin
    unique case ({side_p0_q.dx_pos, side_p0_q.dy_neg})
      2'b00: az_d = ANG_90 - phi_q;
      2'b10: az_d = (phi_q >= ANG_90) ? '0 : phi_q + ANG_270;
      2'b11: az_d = ANG_270 - phi_q;
      2'b01: az_d = ANG_90 + phi_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_p0_q <= '0;
      side_p1_q <= '0;
    end else if (en_i) begin
      side_p0_q <= side_i;
      side_p1_q <= side_p0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phi_q <= phi_d;
      az_q  <= az_d;
    end
  end

  // round half up to output resolution, full circle becomes north
  assign az_rnd = az_q + RND;
  assign az_res = az_rnd[ANG_SHIFT +: AZ_BITS];

  // status priority: border, then nodata, then flat
  always_comb begin
    azimuth_o = '0;
    priority if (side_p1_q.border) begin
      status_o = ST_BORDER;
    end else if (side_p1_q.nodata) begin
      status_o = ST_NODATA;
    end else if (side_p1_q.flat) begin
      status_o = ST_FLAT;
    end else begin
      status_o  = ST_VALID;
      azimuth_o = (az_res >= AZ_FULL) ? '0 : az_res;
    end
  end

  assign valid_o = side_p1_q.vld;

endmodule

`default_nettype wire

@@ src/dema_skid.sv @@
// dema_skid: output register with a skid register behind it
// generic payload width; no package dependency
`default_nettype none

module dema_skid #(
  parameter int W = 17
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         up_valid_i,
  output logic         up_ready_o,
  input  logic [W-1:0] up_data_i,
  output logic         dn_valid_o,
  input  logic         dn_ready_i,
  output logic [W-1:0] dn_data_o
);

  logic         out_vld_q, skid_vld_q;
  logic [W-1:0] out_q, skid_q;
  logic         out_free;

  // output register can load when empty or when its transfer completes
  assign out_free   = ~out_vld_q | dn_ready_i;
  assign up_ready_o = ~skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q | up_valid_i;
      skid_vld_q <= 1'b0;
    end else if (up_valid_i && !skid_vld_q) begin
      skid_vld_q <= 1'b1;
    end
  end

  // skid entry drains first, keeping order
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : up_data_i;
    end
    if (!out_free && !skid_vld_q) begin
      skid_q <= up_data_i;
    end
  end

  assign dn_valid_o = out_vld_q;
  assign dn_data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held while output register empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !dn_ready_i |=> skid_vld_q && $stable(skid_q))
    else $error("skid entry lost during output stall");

  a_skid_catches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !dn_ready_i && up_valid_i && !skid_vld_q
    |=> skid_vld_q && (skid_q == $past(up_data_i)))
    else $error("upstream transfer not captured during output stall");

endmodule

`default_nettype wire

@@ src/dem_aspect_3x3_core.sv @@
// Pipeline: after its input transfer a result passes 6 gradient/normalize stages,
// 27 CORDIC stages, 2 mapping stages and the output register.
// Throughput: one window per cycle; ready drops only once both the output register
// and the skid register hold results that are not yet taken.
// Reset: rst_ni is asynchronous active low; it empties the pipeline and loads the
// nodata register with the most negative elevation code. No clearing pass.
`default_nettype none

module dem_aspect_3x3_core #(
  parameter int ELEV_BITS       = dema_pkg::ELEV_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = dema_pkg::ANGLE_FRAC_BITS_DEF,
  localparam int AZ_BITS        = $clog2(360 * (2 ** ANGLE_FRAC_BITS))
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [ELEV_BITS-1:0] cfg_wdata_i,
  dema_win_if.sink             win_i,
  dema_res_if.source           res_o
);
  import dema_pkg::*;

  localparam logic [AZ_BITS-1:0] AZ_FULL = AZ_BITS'(360 * (2 ** ANGLE_FRAC_BITS));

  logic [ELEV_BITS-1:0]               nodata_q;
  logic [N_CELLS-1:0][ELEV_BITS-1:0]  cells;
  logic                               pipe_en;
  logic signed [CW-1:0]               front_x, front_y;
  dema_side_t                         front_side, cord_side;
  logic signed [ANG_W-1:0]            cord_z;
  logic                               post_valid;
  logic [AZ_BITS-1:0]                 post_az;
  status_e                            post_status;
  logic [AZ_BITS+1:0]                 skid_out;

  // nodata register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodata_q <= {1'b1, {(ELEV_BITS-1){1'b0}}};
    end else if (cfg_we_i) begin
      nodata_q <= cfg_wdata_i;
    end
  end

  // window cells in raster order
  assign cells[CELL_NW] = win_i.elev_nw;
  assign cells[CELL_N]  = win_i.elev_n;
  assign cells[CELL_NE] = win_i.elev_ne;
  assign cells[CELL_W]  = win_i.elev_w;
  assign cells[CELL_C]  = win_i.elev_c;
  assign cells[CELL_E]  = win_i.elev_e;
  assign cells[CELL_SW] = win_i.elev_sw;
  assign cells[CELL_S]  = win_i.elev_s;
  assign cells[CELL_SE] = win_i.elev_se;

  // whole pipeline advances while the skid register is free
  assign win_i.ready = pipe_en;

  dema_front #(
    .ELEV_BITS (ELEV_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .valid_i     (win_i.valid),
    .cells_i     (cells),
    .at_border_i (win_i.at_border),
    .nodata_i    (nodata_q),
    .x_o         (front_x),
    .y_o         (front_y),
    .side_o      (front_side)
  );

  dema_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .x_i    (front_x),
    .y_i    (front_y),
    .side_i (front_side),
    .z_o    (cord_z),
    .side_o (cord_side)
  );

  dema_post #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .AZ_BITS         (AZ_BITS)
  ) u_post (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (pipe_en),
    .z_i       (cord_z),
    .side_i    (cord_side),
    .valid_o   (post_valid),
    .azimuth_o (post_az),
    .status_o  (post_status)
  );

  dema_skid #(
    .W (AZ_BITS + 2)
  ) u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (post_valid),
    .up_ready_o (pipe_en),
    .up_data_i  ({post_az, post_status}),
    .dn_valid_o (res_o.valid),
    .dn_ready_i (res_o.ready),
    .dn_data_o  (skid_out)
  );

  assign res_o.azimuth = skid_out[AZ_BITS+1:2];
  assign res_o.status  = skid_out[1:0];

  a_az_zero_unless_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status != ST_VALID) |-> res_o.azimuth == '0)
    else $error("nonzero azimuth with non-valid status");

  a_az_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status == ST_VALID) |-> res_o.azimuth < AZ_FULL)
    else $error("azimuth beyond full circle");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(cord_side) && $stable(cord_z))
    else $error("rotator output moved during stall");

endmodule

`default_nettype wire
